// ===== src/sorted_table_engine_top_assert.svh =====
// Assertion macros used by the checker file of the sorted table engine.
`ifndef SORTED_TABLE_ENGINE_TOP_ASSERT_SVH
`define SORTED_TABLE_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset.
`define STE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, quiet during reset.
`define STE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ste_pkg.sv =====
package ste_pkg;

  // Default sizes of the table.
  localparam int DEPTH_DEF     = 64;
  localparam int KEY_WIDTH_DEF = 32;

  // Request kinds.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_DELETE = 2'd2,
    OP_DUMP   = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_WAVE = 2'd1,
    S_DUMP = 2'd2
  } state_t;

  // One request beat.
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] key;
    logic [5:0]  position;
  } req_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  index;
    logic [31:0] entry_value;
    logic [6:0]  count;
    logic        last;
  } rsp_t;

  // Controls broadcast from the sequencer to every cell.
  typedef struct packed {
    logic rotate;   // whole row shifts toward cell 0, cell 0 wraps to the end
    logic del;      // cells at or past the delete position take their right neighbor
    logic insert;   // a travelling token is an insert (else a find)
    logic sorted;   // ordered insert
  } ctl_t;

endpackage

// ===== src/ste_cell.sv =====
module ste_cell #(
  parameter int KEY_WIDTH = ste_pkg::KEY_WIDTH_DEF,
  parameter int DEPTH     = ste_pkg::DEPTH_DEF,
  parameter int IDX       = 0
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ste_pkg::ctl_t                    ctl,
  input  logic [$clog2(DEPTH+1)-1:0]       count,
  input  logic [$clog2(DEPTH+1)-1:0]       del_pos,
  input  logic [KEY_WIDTH-1:0]             right_data,
  input  logic                             tok_in,
  input  logic                             hit_in,
  input  logic [$clog2(DEPTH+1)-1:0]       idx_in,
  input  logic [KEY_WIDTH-1:0]             carry_in,
  output logic [KEY_WIDTH-1:0]             data_out,
  output logic                             tok_out,
  output logic                             hit_out,
  output logic [$clog2(DEPTH+1)-1:0]       idx_out,
  output logic [KEY_WIDTH-1:0]             carry_out
);

  localparam int CW = $clog2(DEPTH+1);
  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [KEY_WIDTH-1:0] data;
  logic [KEY_WIDTH-1:0] data_next;
  logic                 tok;
  logic                 hit;
  logic                 hit_next;
  logic [CW-1:0]        idx;
  logic [CW-1:0]        idx_next;
  logic [KEY_WIDTH-1:0] carry;
  logic [KEY_WIDTH-1:0] carry_next;
  logic                 occupied;
  logic                 shift_left;

  assign occupied   = MY_IDX < count;
  assign shift_left = ctl.rotate | (ctl.del & (MY_IDX >= del_pos));

  // Cell update: left shift for delete and dump, otherwise the token decides.
  // An insert token swaps into the first occupied cell holding a larger key (in
  // ordered mode only) or else into the first free cell, and from then on pushes every entry right.
  always_comb begin
    data_next  = data;
    hit_next   = hit_in;
    idx_next   = idx_in;
    carry_next = carry_in;
    if (shift_left) begin
      data_next = right_data;
    end else if (tok_in) begin
      if (ctl.insert) begin
        if (hit_in) begin
          data_next  = carry_in;
          carry_next = data;
        end else if (!occupied || (ctl.sorted && (data > carry_in))) begin
          data_next  = carry_in;
          carry_next = data;
          hit_next   = 1'b1;
          idx_next   = MY_IDX;
        end
      end else if (!hit_in && occupied && (data == carry_in)) begin
        hit_next = 1'b1;
        idx_next = MY_IDX;
      end
    end
  end

  // Stored key.
  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // Token stage handed to the right neighbor.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else begin
      tok <= tok_in & ~shift_left;
    end
  end

  always_ff @(posedge clk) begin
    hit   <= hit_next;
    idx   <= idx_next;
    carry <= carry_next;
  end

  assign data_out  = data;
  assign tok_out   = tok;
  assign hit_out   = hit;
  assign idx_out   = idx;
  assign carry_out = carry;

endmodule

// ===== src/sorted_table_engine_top.sv =====
// Channel  Beat           Handshake               Direction
// request  req (req_t)    start high, busy low    in
// result   rsp (rsp_t)    rsp_valid, one cycle    out
// config   cfg_wdata      cfg_we                  in
//
// Insert and find: a token walks the row of cells one cell per cycle; busy is
// high until the token leaves the last cell, and the result is registered from the last cell's outputs.
// Delete, full insert and empty dump: the result strobes in the next cycle.
// Dump: busy while the row rotates through every cell; one beat per stored entry,
// registered from cell 0 at each rotation step.
// Reset (rst, synchronous) empties the table; the receiver cannot stall.
module sorted_table_engine_top #(
  parameter int DEPTH     = ste_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = ste_pkg::KEY_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ste_pkg::req_t req,
  output logic          rsp_valid,
  output ste_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);

  localparam int CW   = $clog2(DEPTH+1);
  localparam int SW   = $clog2(DEPTH);
  localparam int CMPW = (CW > 6) ? CW : 6;

  ste_pkg::state_t      state;
  ste_pkg::state_t      state_next;
  ste_pkg::op_t         op_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic [SW-1:0]        step;
  logic [SW-1:0]        step_next;
  logic                 launch;
  logic                 launch_next;
  logic                 sorted_mode;
  logic                 rsp_valid_next;
  ste_pkg::rsp_t        rsp_next;
  ste_pkg::ctl_t        ctl;
  logic [CW-1:0]        del_pos;
  logic                 accept;
  logic                 full;
  logic                 pos_ok;

  logic [KEY_WIDTH-1:0] data_w  [DEPTH];
  logic                 tok_w   [DEPTH+1];
  logic                 hit_w   [DEPTH+1];
  logic [CW-1:0]        idx_w   [DEPTH+1];
  logic [KEY_WIDTH-1:0] carry_w [DEPTH+1];

  assign accept = start & ~busy;
  assign full   = count == CW'(DEPTH);
  assign pos_ok = CMPW'(req.position) < CMPW'(count);

  // Token entry point of the row.
  assign tok_w[0]   = launch;
  assign hit_w[0]   = 1'b0;
  assign idx_w[0]   = '0;
  assign carry_w[0] = key_q;

  // Row of cells; the right neighbor of the last cell is cell 0.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    ste_cell #(
      .KEY_WIDTH(KEY_WIDTH),
      .DEPTH    (DEPTH),
      .IDX      (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .count     (count),
      .del_pos   (del_pos),
      .right_data(data_w[(g+1) % DEPTH]),
      .tok_in    (tok_w[g]),
      .hit_in    (hit_w[g]),
      .idx_in    (idx_w[g]),
      .carry_in  (carry_w[g]),
      .data_out  (data_w[g]),
      .tok_out   (tok_w[g+1]),
      .hit_out   (hit_w[g+1]),
      .idx_out   (idx_w[g+1]),
      .carry_out (carry_w[g+1])
    );
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ste_pkg::S_IDLE: begin
        if (accept) begin
          case (req.mode)
            ste_pkg::OP_INSERT: state_next = full ? ste_pkg::S_IDLE : ste_pkg::S_WAVE;
            ste_pkg::OP_FIND:   state_next = ste_pkg::S_WAVE;
            ste_pkg::OP_DUMP:   state_next = (count == '0) ? ste_pkg::S_IDLE
                                                           : ste_pkg::S_DUMP;
            default:            state_next = ste_pkg::S_IDLE;
          endcase
        end
      end
      ste_pkg::S_WAVE: begin
        if (tok_w[DEPTH]) begin
          state_next = ste_pkg::S_IDLE;
        end
      end
      ste_pkg::S_DUMP: begin
        if (step == SW'(DEPTH-1)) begin
          state_next = ste_pkg::S_IDLE;
        end
      end
      default: state_next = ste_pkg::S_IDLE;
    endcase
  end

  // Outputs, row controls and result beats.
  always_comb begin
    busy             = state != ste_pkg::S_IDLE;
    ctl.rotate       = state == ste_pkg::S_DUMP;
    ctl.del          = 1'b0;
    ctl.insert       = op_q == ste_pkg::OP_INSERT;
    ctl.sorted       = sorted_mode;
    del_pos          = CW'(req.position);
    count_next       = count;
    step_next        = step;
    launch_next      = 1'b0;
    rsp_valid_next   = 1'b0;
    rsp_next         = rsp;
    rsp_next.entry_value = '0;
    rsp_next.last    = 1'b1;
    case (state)
      ste_pkg::S_IDLE: begin
        if (accept) begin
          case (req.mode)
            ste_pkg::OP_INSERT: begin
              if (full) begin
                rsp_valid_next = 1'b1;
                rsp_next.status = ste_pkg::ST_FULL;
                rsp_next.index  = 7'(count);
                rsp_next.count  = 7'(count);
              end else begin
                launch_next = 1'b1;
              end
            end
            ste_pkg::OP_FIND: begin
              launch_next = 1'b1;
            end
            ste_pkg::OP_DELETE: begin
              rsp_valid_next = 1'b1;
              rsp_next.index = 7'(req.position);
              if (pos_ok) begin
                ctl.del         = 1'b1;
                count_next      = count - CW'(1);
                rsp_next.status = ste_pkg::ST_OK;
                rsp_next.count  = 7'(count - CW'(1));
              end else begin
                rsp_next.status = ste_pkg::ST_BAD_POS;
                rsp_next.count  = 7'(count);
              end
            end
            default: begin
              step_next = '0;
              if (count == '0) begin
                rsp_valid_next  = 1'b1;
                rsp_next.status = ste_pkg::ST_NOT_FOUND;
                rsp_next.index  = '0;
                rsp_next.count  = '0;
              end
            end
          endcase
        end
      end
      ste_pkg::S_WAVE: begin
        if (tok_w[DEPTH]) begin
          rsp_valid_next = 1'b1;
          if (op_q == ste_pkg::OP_INSERT) begin
            count_next      = count + CW'(1);
            rsp_next.status = ste_pkg::ST_OK;
            rsp_next.index  = 7'(idx_w[DEPTH]);
            rsp_next.count  = 7'(count + CW'(1));
          end else if (hit_w[DEPTH]) begin
            rsp_next.status = ste_pkg::ST_OK;
            rsp_next.index  = 7'(idx_w[DEPTH]);
            rsp_next.count  = 7'(count);
          end else begin
            rsp_next.status = ste_pkg::ST_NOT_FOUND;
            rsp_next.index  = 7'(count);
            rsp_next.count  = 7'(count);
          end
        end
      end
      ste_pkg::S_DUMP: begin
        // Cell 0 holds the entry whose index equals the rotation step.
        step_next            = step + SW'(1);
        rsp_valid_next       = CW'(step) < count;
        rsp_next.status      = ste_pkg::ST_OK;
        rsp_next.index       = 7'(step);
        rsp_next.entry_value = 32'(data_w[0]);
        rsp_next.count       = 7'(count);
        rsp_next.last        = (CW'(step) + CW'(1)) == count;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ste_pkg::S_IDLE;
      count       <= '0;
      launch      <= 1'b0;
      rsp_valid   <= 1'b0;
      sorted_mode <= 1'b1;
    end else begin
      state     <= state_next;
      count     <= count_next;
      launch    <= launch_next;
      rsp_valid <= rsp_valid_next;
      if (cfg_we) begin
        sorted_mode <= cfg_wdata;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    step <= step_next;
    rsp  <= rsp_next;
    if (accept) begin
      op_q  <= ste_pkg::op_t'(req.mode);
      key_q <= KEY_WIDTH'(req.key);
    end
  end

endmodule

// ===== src/ste_checker.sv =====
`include "sorted_table_engine_top_assert.svh"

module ste_checker (
  input logic          clk,
  input logic          rst,
  input logic          busy,
  input logic          rsp_valid,
  input ste_pkg::rsp_t rsp
);

  // A dump beat that is not the final one is followed by the next index.
  `STE_ASSERT_NXT(a_dump_stream, rsp_valid && !rsp.last, rsp_valid && (rsp.index == $past(rsp.index) + 7'd1), "dump beats not contiguous")

  // The engine stays busy while a dump still has beats to give.
  `STE_ASSERT_IMP(a_dump_busy, rsp_valid && !rsp.last, busy, "idle in the middle of a dump")

  // Any beat that is not ok is a single-beat answer with no entry value.
  `STE_ASSERT_IMP(a_err_single, rsp_valid && (rsp.status != ste_pkg::ST_OK), rsp.last && (rsp.entry_value == 32'd0), "error beat with payload")

  // A rejected insert reports the count as its index.
  `STE_ASSERT_IMP(a_full_index, rsp_valid && (rsp.status == ste_pkg::ST_FULL), rsp.index == rsp.count, "full beat index differs from count")

endmodule

bind sorted_table_engine_top ste_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .busy     (busy),
  .rsp_valid(rsp_valid),
  .rsp      (rsp)
);

// ===== tb/sorted_table_engine_top_tb.sv =====
`timescale 1ns / 100ps

module sorted_table_engine_top_tb;

  // Cycles without any accepted request or result before the run is abandoned.
  localparam int QUIET_LIMIT = 2000;
  // Extra cycles allowed after the last result, covering the longest walk.
  localparam int SETTLE_CYCLES = ste_pkg::DEPTH_DEF + 4;

  // Tracks the table contents and holds the result beats still owed by the block.
  class table_tracker;
    logic [31:0]   keys[ste_pkg::DEPTH_DEF];
    int            fill;
    bit            sorted_on;
    ste_pkg::rsp_t owed_beats[$];
    int            errors;
    int            beats_checked;
    int            op_seen[4];
    int            full_hits;
    int            bad_deletes;
    int            find_misses;
    int            empty_dumps;

    function new();
      fill      = 0;
      sorted_on = 1'b1;
      errors    = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
      foreach (keys[i]) keys[i] = '0;
    endfunction

    function int pending();
      return owed_beats.size();
    endfunction

    function logic [31:0] key_at(int slot);
      return keys[slot];
    endfunction

    // Work out every beat an accepted request causes and update the table copy.
    function void note_request(ste_pkg::req_t item);
      ste_pkg::rsp_t beat;
      int            at;
      int            pos;
      bit            hit;
      beat      = '0;
      beat.last = 1'b1;
      op_seen[item.mode]++;
      case (ste_pkg::op_t'(item.mode))
        ste_pkg::OP_INSERT: begin
          if (fill == ste_pkg::DEPTH_DEF) begin
            beat.status = ste_pkg::ST_FULL;
            beat.index  = 7'(fill);
            full_hits++;
          end else begin
            // Ordered insert lands after all equal keys; append lands at the end.
            at = fill;
            if (sorted_on) begin
              for (int i = fill - 1; i >= 0; i--) begin
                if (keys[i] > item.key) at = i;
              end
            end
            for (int i = fill; i > at; i--) keys[i] = keys[i - 1];
            keys[at]    = item.key;
            fill++;
            beat.status = ste_pkg::ST_OK;
            beat.index  = 7'(at);
          end
          beat.count = 7'(fill);
          owed_beats.push_back(beat);
        end
        ste_pkg::OP_FIND: begin
          hit = 1'b0;
          for (int i = 0; i < fill; i++) begin
            if (!hit && keys[i] == item.key) begin
              hit        = 1'b1;
              beat.index = 7'(i);
            end
          end
          if (hit) begin
            beat.status = ste_pkg::ST_OK;
          end else begin
            beat.status = ste_pkg::ST_NOT_FOUND;
            beat.index  = 7'(fill);
            find_misses++;
          end
          beat.count = 7'(fill);
          owed_beats.push_back(beat);
        end
        ste_pkg::OP_DELETE: begin
          pos = item.position;
          if (pos >= fill) begin
            beat.status = ste_pkg::ST_BAD_POS;
            bad_deletes++;
          end else begin
            for (int i = pos; i + 1 < fill; i++) keys[i] = keys[i + 1];
            fill--;
            beat.status = ste_pkg::ST_OK;
          end
          beat.index = 7'(pos);
          beat.count = 7'(fill);
          owed_beats.push_back(beat);
        end
        default: begin
          if (fill == 0) begin
            beat.status = ste_pkg::ST_NOT_FOUND;
            empty_dumps++;
            owed_beats.push_back(beat);
          end else begin
            for (int i = 0; i < fill; i++) begin
              beat.status      = ste_pkg::ST_OK;
              beat.index       = 7'(i);
              beat.entry_value = keys[i];
              beat.count       = 7'(fill);
              beat.last        = (i == fill - 1);
              owed_beats.push_back(beat);
            end
          end
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 100) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("beat %0d field %s got %0h expected %0h",
                                  beats_checked, name, got, want));
    endtask

    // Compare one result beat with the oldest owed beat.
    task check_result(ste_pkg::rsp_t got);
      ste_pkg::rsp_t want;
      if (owed_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat status %0d index %0d",
                                  got.status, got.index));
      end else begin
        want = owed_beats.pop_front();
        compare_field("status", 32'(got.status), 32'(want.status));
        compare_field("index", 32'(got.index), 32'(want.index));
        compare_field("entry_value", got.entry_value, want.entry_value);
        compare_field("count", 32'(got.count), 32'(want.count));
        compare_field("last", 32'(got.last), 32'(want.last));
      end
      beats_checked++;
    endtask
  endclass

  logic          clk = 1'b0;
  logic          rst;
  logic          start;
  logic          busy;
  ste_pkg::req_t req;
  logic          rsp_valid;
  ste_pkg::rsp_t rsp;
  logic          cfg_we;
  logic          cfg_wdata;

  table_tracker tracker;
  int           quiet_cycles;

  sorted_table_engine_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result checking and the watchdog for a stuck block.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (rsp_valid === 1'b1) tracker.check_result(rsp);
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog: no request or result for %0d cycles.", QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic ste_pkg::req_t make_req(ste_pkg::op_t op, logic [31:0] key,
                                             logic [5:0] position);
    ste_pkg::req_t item;
    item.mode     = op;
    item.key      = key;
    item.position = position;
    return item;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Keys lean toward extremes, small values for duplicates and stored keys for hits.
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2, 3, 4: return 32'($urandom_range(0, 15));
      5, 6: begin
        if (tracker.fill > 0) return tracker.key_at($urandom_range(0, tracker.fill - 1));
        return $urandom();
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [5:0] pick_position();
    if (tracker.fill > 0 && $urandom_range(0, 3) != 0)
      return 6'($urandom_range(0, tracker.fill - 1));
    return 6'($urandom_range(0, 63));
  endfunction

  // Present one request beat and hold it until the block takes it.
  task automatic send_request(input ste_pkg::req_t item, input int gap);
    start <= 1'b1;
    req   <= item;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    tracker.note_request(item);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending until every owed beat has come back.
  task automatic drain(input int extra);
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending() > 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_sorted_mode(input logic value);
    drain(SETTLE_CYCLES);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.sorted_on = value;
  endtask

  // Random requests with the given percentages; the rest are dumps.
  task automatic random_phase(input int items, input int w_ins, input int w_find,
                              input int w_del);
    int           roll;
    ste_pkg::op_t op;
    for (int n = 0; n < items; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < w_ins) op = ste_pkg::OP_INSERT;
      else if (roll < w_ins + w_find) op = ste_pkg::OP_FIND;
      else if (roll < w_ins + w_find + w_del) op = ste_pkg::OP_DELETE;
      else op = ste_pkg::OP_DUMP;
      send_request(make_req(op, pick_key(), pick_position()), (n < 8) ? 0 : pick_gap());
      if (n == items / 2 && $urandom_range(0, 1) == 1) drain(0);
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    req       = '0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    tracker   = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    write_sorted_mode(1'b1);

    // Empty table: dump, miss and out-of-range deletes.
    send_request(make_req(ste_pkg::OP_DUMP, 32'h0, 6'd0), pick_gap());
    send_request(make_req(ste_pkg::OP_FIND, 32'd7, 6'd0), pick_gap());
    send_request(make_req(ste_pkg::OP_DELETE, 32'h0, 6'd0), pick_gap());
    send_request(make_req(ste_pkg::OP_DELETE, 32'hFFFF_FFFF, 6'd63), pick_gap());

    // Ordered inserts at both key extremes and with a duplicate key.
    send_request(make_req(ste_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd0), pick_gap());
    send_request(make_req(ste_pkg::OP_INSERT, 32'h0, 6'd0), pick_gap());
    send_request(make_req(ste_pkg::OP_INSERT, 32'd5, 6'd0), pick_gap());
    send_request(make_req(ste_pkg::OP_INSERT, 32'd5, 6'd63), pick_gap());
    send_request(make_req(ste_pkg::OP_INSERT, 32'd3, 6'd0), pick_gap());
    send_request(make_req(ste_pkg::OP_FIND, 32'd5, 6'd0), pick_gap());
    send_request(make_req(ste_pkg::OP_FIND, 32'h0, 6'd0), pick_gap());
    send_request(make_req(ste_pkg::OP_FIND, 32'hFFFF_FFFF, 6'd0), pick_gap());
    send_request(make_req(ste_pkg::OP_FIND, 32'd6, 6'd0), pick_gap());
    send_request(make_req(ste_pkg::OP_DUMP, 32'h0, 6'd0), pick_gap());

    // Deletes in the middle, at the last entry and one past the end.
    send_request(make_req(ste_pkg::OP_DELETE, 32'h0, 6'd1), pick_gap());
    send_request(make_req(ste_pkg::OP_DELETE, 32'h0, 6'd3), pick_gap());
    send_request(make_req(ste_pkg::OP_DELETE, 32'h0, 6'd3), pick_gap());
    send_request(make_req(ste_pkg::OP_DUMP, 32'h0, 6'd0), pick_gap());

    // Append mode breaks the order; a find still reports the lowest match.
    write_sorted_mode(1'b0);
    send_request(make_req(ste_pkg::OP_INSERT, 32'd9, 6'd0), pick_gap());
    send_request(make_req(ste_pkg::OP_INSERT, 32'd1, 6'd0), pick_gap());
    send_request(make_req(ste_pkg::OP_INSERT, 32'd9, 6'd0), pick_gap());
    send_request(make_req(ste_pkg::OP_FIND, 32'd9, 6'd0), pick_gap());
    send_request(make_req(ste_pkg::OP_DUMP, 32'h0, 6'd0), pick_gap());

    // Ordered insert into data that is no longer sorted.
    write_sorted_mode(1'b1);
    send_request(make_req(ste_pkg::OP_INSERT, 32'd4, 6'd0), pick_gap());
    send_request(make_req(ste_pkg::OP_DUMP, 32'h0, 6'd0), pick_gap());

    // Fill the table, then push against the full limit.
    random_phase(75, 80, 8, 5);
    while (tracker.fill < ste_pkg::DEPTH_DEF)
      send_request(make_req(ste_pkg::OP_INSERT, pick_key(), pick_position()), pick_gap());
    send_request(make_req(ste_pkg::OP_INSERT, pick_key(), pick_position()), pick_gap());
    send_request(make_req(ste_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd63), pick_gap());

    // Mixed traffic in both modes, then mostly deletes to empty the table.
    write_sorted_mode(1'b0);
    random_phase(45, 30, 30, 30);
    write_sorted_mode(1'b1);
    random_phase(35, 45, 25, 25);
    write_sorted_mode(1'b0);
    random_phase(40, 10, 20, 65);

    drain(SETTLE_CYCLES);
    $display("Ran %0d inserts, %0d finds, %0d deletes and %0d dumps; %0d beats checked.",
             tracker.op_seen[ste_pkg::OP_INSERT], tracker.op_seen[ste_pkg::OP_FIND],
             tracker.op_seen[ste_pkg::OP_DELETE], tracker.op_seen[ste_pkg::OP_DUMP],
             tracker.beats_checked);
    $display("Saw %0d full-table inserts, %0d bad deletes, %0d find misses, %0d empty dumps.",
             tracker.full_hits, tracker.bad_deletes, tracker.find_misses,
             tracker.empty_dumps);
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
